/* rtl/rcmm_pkg.sv */
`timescale 1ns / 1ps
// Package for the RCMM infrared frame encoder: field widths, operation,
// register and phase codes, segment lengths and the gap lookup. No dependencies.
package rcmm_pkg;

    localparam int CMD_W       = 32;
    localparam int OP_W        = 2;
    localparam int DUR_W       = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int PHASE_W     = 3;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND   = 2'd1;
    localparam logic [OP_W-1:0] OP_REPEAT = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BITS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAILER_ENABLE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOGGLE_POSITION = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAUSE_TICKS     = 3'd3;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR_ON  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HDR_OFF = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SYM_ON  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SYM_OFF = 3'd4;
    localparam logic [PHASE_W-1:0] PH_TRAIL   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_WAIT    = 3'd6;

    localparam logic [DUR_W-1:0] DUR_HDR_ON    = 5'd15;
    localparam logic [DUR_W-1:0] DUR_HDR_OFF   = 5'd10;
    localparam logic [DUR_W-1:0] DUR_PULSE     = 5'd6;
    localparam logic [DUR_W-1:0] DUR_NO_TRAIL  = 5'd1;

    localparam logic [5:0] RESET_FRAME_BITS      = 6'd32;
    localparam logic       RESET_TRAILER_ENABLE  = 1'b1;
    localparam logic [5:0] RESET_TOGGLE_POSITION = 6'd0;
    localparam logic [7:0] RESET_PAUSE_TICKS     = 8'd110;

    typedef struct packed {
        logic             carrier_on;
        logic [DUR_W-1:0] duration;
        logic             frame_started;
        logic             busy_res;
    } rcmm_result_t;

    function automatic logic [DUR_W-1:0] gap_len(input logic [1:0] pair);
        logic [DUR_W-1:0] len;
        case (pair)
            2'd0:    len = 5'd10;
            2'd1:    len = 5'd16;
            2'd2:    len = 5'd22;
            default: len = 5'd28;
        endcase
        return len;
    endfunction

endpackage

/* rtl/rcmm_if.sv */
`timescale 1ns / 1ps
// Channel interfaces of the RCMM infrared frame encoder: request, result and
// configuration write. Depends on rcmm_pkg.
interface rcmm_req_if
    import rcmm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [CMD_W-1:0] command;

    modport source (output valid, output operation, output command, input ready);
    modport sink (input valid, input operation, input command, output ready);
endinterface

interface rcmm_res_if
    import rcmm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             carrier_on;
    logic [DUR_W-1:0] duration;
    logic             frame_started;
    logic             busy_res;

    modport source (output valid, output carrier_on, output duration,
                    output frame_started, output busy_res, input ready);
    modport sink (input valid, input carrier_on, input duration,
                  input frame_started, input busy_res, output ready);
endinterface

interface rcmm_cfg_if
    import rcmm_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/rcmm_ir_frame_encoder_top.sv */
`timescale 1ns / 1ps
// Top level of the RCMM infrared frame encoder: frame sequencer, configuration
// registers and a two-entry result buffer. Depends on rcmm_pkg and rcmm_if.
//
//  Channel   Direction  Beat contents
//  request   in         operation, command
//  result    out        carrier_on, duration, frame_started, busy_res
//  cfg       in         index, data (register write, always ready)
//
// Each request beat is processed in the cycle it is accepted and its result is
// registered; a new beat is accepted every cycle while the skid entry is empty.
// The result side has a main and a skid register, so one stalled result does
// not block the request side; request ready drops only while both are full.
// Reset is asynchronous and active low; it sets the registers to their
// documented values and empties the result buffer.
module rcmm_ir_frame_encoder_top
    import rcmm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rcmm_req_if.sink   request,
    rcmm_res_if.source result,
    rcmm_cfg_if.sink   cfg
);

    logic [5:0]         frame_bits_reg;
    logic               trailer_enable_reg;
    logic [5:0]         toggle_position_reg;
    logic [7:0]         pause_ticks_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CMD_W-1:0]   shift_word_reg, shift_word_next;
    logic [5:0]         bits_sent_reg, bits_sent_next;
    logic [7:0]         wait_count_reg, wait_count_next;
    logic [CMD_W-1:0]   held_command_reg, held_command_next;
    logic               toggle_flag_reg, toggle_flag_next;
    logic               carrier_reg, carrier_next;
    logic [DUR_W-1:0]   duration_reg, duration_next;
    logic               started;

    logic [6:0]         bits_sum;
    logic [7:0]         wait_inc;
    logic [5:0]         toggle_pos_m1;
    logic [CMD_W-1:0]   toggle_mask;
    logic [CMD_W-1:0]   send_command;
    logic               toggle_active;

    rcmm_result_t       res_new;
    rcmm_result_t       main_reg;
    rcmm_result_t       skid_reg;
    logic               main_valid_reg;
    logic               skid_valid_reg;
    logic               accept;
    logic               pop;

    assign accept = request.valid && request.ready;
    assign pop    = main_valid_reg && result.ready;
    assign request.ready = !skid_valid_reg;
    assign cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bits_reg      <= RESET_FRAME_BITS;
            trailer_enable_reg  <= RESET_TRAILER_ENABLE;
            toggle_position_reg <= RESET_TOGGLE_POSITION;
            pause_ticks_reg     <= RESET_PAUSE_TICKS;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_FRAME_BITS:      frame_bits_reg      <= cfg.data[5:0];
                CFG_TRAILER_ENABLE:  trailer_enable_reg  <= cfg.data[0];
                CFG_TOGGLE_POSITION: toggle_position_reg <= cfg.data[5:0];
                CFG_PAUSE_TICKS:     pause_ticks_reg     <= cfg.data;
                default:             ;
            endcase
        end
    end

    assign bits_sum      = {1'b0, bits_sent_reg} + 7'd2;
    assign wait_inc      = wait_count_reg + 8'd1;
    assign toggle_pos_m1 = toggle_position_reg - 6'd1;
    assign toggle_mask   = CMD_W'(1) << toggle_pos_m1[4:0];
    assign toggle_active = (toggle_position_reg != 6'd0) && (toggle_position_reg <= 6'd32);

    always_comb
    begin
        send_command = request.command;
        if (toggle_active && request.command != '0)
        begin
            if (toggle_flag_reg)
            begin
                send_command = request.command & ~toggle_mask;
            end
            else
            begin
                send_command = request.command | toggle_mask;
            end
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        shift_word_next   = shift_word_reg;
        bits_sent_next    = bits_sent_reg;
        wait_count_next   = wait_count_reg;
        held_command_next = held_command_reg;
        toggle_flag_next  = toggle_flag_reg;
        carrier_next      = carrier_reg;
        duration_next     = duration_reg;
        started           = 1'b0;

        case (request.operation)
            OP_TICK:
            begin
                case (phase_reg)
                    PH_HDR_ON:
                    begin
                        carrier_next  = 1'b1;
                        duration_next = DUR_HDR_ON;
                        phase_next    = PH_HDR_OFF;
                    end
                    PH_HDR_OFF:
                    begin
                        carrier_next  = 1'b0;
                        duration_next = DUR_HDR_OFF;
                        phase_next    = PH_SYM_ON;
                    end
                    PH_SYM_ON:
                    begin
                        carrier_next  = 1'b1;
                        duration_next = DUR_PULSE;
                        phase_next    = PH_SYM_OFF;
                    end
                    PH_SYM_OFF:
                    begin
                        carrier_next    = 1'b0;
                        duration_next   = gap_len(shift_word_reg[CMD_W-1 -: 2]);
                        shift_word_next = {shift_word_reg[CMD_W-3:0], 2'b00};
                        bits_sent_next  = bits_sum[5:0];
                        phase_next      = (bits_sum >= {1'b0, frame_bits_reg})
                                          ? PH_TRAIL : PH_SYM_ON;
                    end
                    PH_TRAIL:
                    begin
                        if (trailer_enable_reg)
                        begin
                            carrier_next  = 1'b1;
                            duration_next = DUR_PULSE;
                        end
                        else
                        begin
                            duration_next = DUR_NO_TRAIL;
                        end
                        phase_next = PH_WAIT;
                    end
                    PH_WAIT:
                    begin
                        carrier_next    = 1'b0;
                        duration_next   = DUR_PULSE;
                        wait_count_next = wait_inc;
                        if (wait_inc >= pause_ticks_reg)
                        begin
                            bits_sent_next  = 6'd0;
                            wait_count_next = 8'd0;
                            phase_next      = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        carrier_next = 1'b0;
                        phase_next   = PH_IDLE;
                    end
                endcase
            end
            OP_SEND:
            begin
                held_command_next = send_command;
                if (send_command != '0 && phase_reg == PH_IDLE)
                begin
                    shift_word_next = send_command;
                    phase_next      = PH_HDR_ON;
                    started         = 1'b1;
                end
            end
            OP_REPEAT:
            begin
                if (held_command_reg != '0 && phase_reg == PH_IDLE)
                begin
                    shift_word_next = held_command_reg;
                    phase_next      = PH_HDR_ON;
                    started         = 1'b1;
                end
            end
            default:
            begin
                held_command_next = '0;
                toggle_flag_next  = !toggle_flag_reg;
            end
        endcase
    end

    assign res_new.carrier_on    = carrier_next;
    assign res_new.duration      = duration_next;
    assign res_new.frame_started = started;
    assign res_new.busy_res      = (phase_next != PH_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            shift_word_reg   <= '0;
            bits_sent_reg    <= '0;
            wait_count_reg   <= '0;
            held_command_reg <= '0;
            toggle_flag_reg  <= 1'b0;
            carrier_reg      <= 1'b0;
            duration_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            shift_word_reg   <= shift_word_next;
            bits_sent_reg    <= bits_sent_next;
            wait_count_reg   <= wait_count_next;
            held_command_reg <= held_command_next;
            toggle_flag_reg  <= toggle_flag_next;
            carrier_reg      <= carrier_next;
            duration_reg     <= duration_next;
        end
    end

    // Result buffer: the skid entry fills only while the main entry is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!accept)
            begin
                main_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (accept)
            begin
                main_reg <= res_new;
            end
        end
        else if (accept)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= res_new;
            end
            else
            begin
                main_reg <= res_new;
            end
        end
    end

    assign result.valid         = main_valid_reg;
    assign result.carrier_on    = main_reg.carrier_on;
    assign result.duration      = main_reg.duration;
    assign result.frame_started = main_reg.frame_started;
    assign result.busy_res      = main_reg.busy_res;

`ifndef SYNTH
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry holds a result while the main entry is empty");

    a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (bits_sent_reg == 6'd0 && wait_count_reg == 8'd0))
        else $error("frame counters not cleared while idle");

    a_stop_clears_command: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.operation == OP_STOP) |=> (held_command_reg == '0))
        else $error("stop did not clear the held command");

    a_start_only_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && started) |-> (phase_reg == PH_IDLE && phase_next == PH_HDR_ON))
        else $error("frame started outside the idle phase");
`endif

endmodule
